@@ src/md5_pkg.sv @@
// md5_pkg: shared types, constants and round helpers for the md5 digest engine
// used by md5_round_unit and md5_digest_engine; no dependencies
`default_nettype none

package md5_pkg;

    // chaining word initial values h0..h3
    localparam logic [31:0] IV_H0 = 32'h67452301;
    localparam logic [31:0] IV_H1 = 32'hefcdab89;
    localparam logic [31:0] IV_H2 = 32'h98badcfe;
    localparam logic [31:0] IV_H3 = 32'h10325476;

    // pad marker byte, slot positions of the length words, bytes per word, last digest index and last round
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [3:0] SLOT_LEN_LO = 4'd14;
    localparam logic [3:0] SLOT_LEN_HI = 4'd15;
    localparam logic [2:0] FULL_BYTES  = 3'd4;
    localparam logic [1:0] LAST_INDEX  = 2'd3;
    localparam logic [5:0] LAST_ROUND  = 6'd63;

    // per-round additive constants
    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // input-side sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_BLOCK,
        ST_OUT
    } eng_state_t;

    // round unit states
    typedef enum logic [1:0] {
        RU_IDLE,
        RU_LOAD,
        RU_ROUND,
        RU_ADD
    } ru_state_t;

    typedef logic [3:0][31:0] chain_t;

    // control from the sequencer into the round unit
    typedef struct packed {
        logic        start;
        logic        clear_chain;
        logic        wr_en;
        logic [3:0]  wr_addr;
        logic [31:0] wr_data;
    } ru_ctrl_t;

    // status from the round unit
    typedef struct packed {
        logic   done;
        chain_t chain;
    } ru_stat_t;

    // message word index used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = lo;
            2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
            2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
            default: idx = 4'(lo * 4'd7);
        endcase
        return idx;
    endfunction

    // left rotate amount of a round
    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        logic [4:0] amt;
        case ({rnd[5:4], rnd[1:0]})
            4'b0000: amt = 5'd7;
            4'b0001: amt = 5'd12;
            4'b0010: amt = 5'd17;
            4'b0011: amt = 5'd22;
            4'b0100: amt = 5'd5;
            4'b0101: amt = 5'd9;
            4'b0110: amt = 5'd14;
            4'b0111: amt = 5'd20;
            4'b1000: amt = 5'd4;
            4'b1001: amt = 5'd11;
            4'b1010: amt = 5'd16;
            4'b1011: amt = 5'd23;
            4'b1100: amt = 5'd6;
            4'b1101: amt = 5'd10;
            4'b1110: amt = 5'd15;
            default: amt = 5'd21;
        endcase
        return amt;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

endpackage

`default_nettype wire

@@ src/md5_digest_engine.sv @@
// md5_digest_engine: stream in little-endian message words, stream out h0..h3
// input: one message word per cycle while the input is open; every 16th word starts a
// block run (load, 64 rounds from the block memory, chaining add) with input held off
// last word: padding writes and one or two block runs, then four digest transfers
// on the master side
// reset: chaining words to the md5 initial values, counters and flags to zero
`default_nettype none

module md5_digest_engine
    import md5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // msg_word[31:0]
    input  wire logic [2:0]  s_tuser,   // valid_bytes[2:0]
    input  wire logic        s_tlast,   // last_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // digest_word[31:0]
    output logic [1:0]       m_tuser,   // digest_index[1:0]
    output logic             m_tlast    // digest_last
);

    eng_state_t  state_reg, state_next;
    logic [3:0]  slot_reg, slot_next;
    logic [63:0] byte_total_reg, byte_total_next;
    logic        pend_pad_reg, pend_pad_next;
    logic        len_lo_reg, len_lo_next;
    logic        fin_reg, fin_next;
    logic        pad_reg, pad_next;
    logic [1:0]  idx_reg, idx_next;

    ru_ctrl_t    ctrl;
    ru_stat_t    stat;

    logic        in_fire;
    logic        out_fire;
    logic [2:0]  nb_clip;
    logic [31:0] tail_word;
    logic [31:0] pad_word;
    logic [63:0] bit_len;

    md5_round_unit u_round
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign nb_clip  = (s_tuser > FULL_BYTES) ? FULL_BYTES : s_tuser;
    assign bit_len  = {byte_total_reg[60:0], 3'b000};

    // final word: keep valid lanes, pad byte in the first empty lane if there is one
    always_comb
    begin
        case (nb_clip)
            3'd0:    tail_word = {24'd0, PAD_BYTE};
            3'd1:    tail_word = {16'd0, PAD_BYTE, s_tdata[7:0]};
            3'd2:    tail_word = {8'd0, PAD_BYTE, s_tdata[15:0]};
            3'd3:    tail_word = {PAD_BYTE, s_tdata[23:0]};
            default: tail_word = s_tdata;
        endcase
    end

    // padding word for the current slot
    always_comb
    begin
        if (pend_pad_reg)
            pad_word = {24'd0, PAD_BYTE};
        else if (slot_reg == SLOT_LEN_LO)
            pad_word = bit_len[31:0];
        else if (slot_reg == SLOT_LEN_HI && len_lo_reg)
            pad_word = bit_len[63:32];
        else
            pad_word = 32'd0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (slot_reg == SLOT_LEN_HI)
                        state_next = ST_BLOCK;
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (slot_reg == SLOT_LEN_HI)
                    state_next = ST_BLOCK;
            end
            ST_BLOCK:
            begin
                if (stat.done)
                begin
                    if (fin_reg)
                        state_next = ST_OUT;
                    else if (pad_reg)
                        state_next = ST_PAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_fire && idx_reg == LAST_INDEX)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake and round unit control
    always_comb
    begin
        s_tready          = (state_reg == ST_IDLE);
        m_tvalid          = (state_reg == ST_OUT);
        ctrl.start        = 1'b0;
        ctrl.clear_chain  = 1'b0;
        ctrl.wr_en        = 1'b0;
        ctrl.wr_addr      = slot_reg;
        ctrl.wr_data      = pad_word;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ctrl.wr_en   = 1'b1;
                    ctrl.wr_data = s_tlast ? tail_word : s_tdata;
                    ctrl.start   = (slot_reg == SLOT_LEN_HI);
                end
            end
            ST_PAD:
            begin
                ctrl.wr_en = 1'b1;
                ctrl.start = (slot_reg == SLOT_LEN_HI);
            end
            ST_OUT:
            begin
                ctrl.clear_chain = out_fire && (idx_reg == LAST_INDEX);
            end
            default:
            begin
                ctrl.wr_en = 1'b0;
            end
        endcase
    end

    // digest output straight from the chaining registers
    assign m_tdata = stat.chain[idx_reg];
    assign m_tuser = idx_reg;
    assign m_tlast = (idx_reg == LAST_INDEX);

    // counters and padding flags
    always_comb
    begin
        slot_next       = slot_reg;
        byte_total_next = byte_total_reg;
        pend_pad_next   = pend_pad_reg;
        len_lo_next     = len_lo_reg;
        fin_next        = fin_reg;
        pad_next        = pad_reg;
        idx_next        = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    slot_next = 4'(slot_reg + 4'd1);
                    if (s_tlast)
                    begin
                        byte_total_next = byte_total_reg + 64'(nb_clip);
                        pad_next        = 1'b1;
                        pend_pad_next   = (nb_clip == FULL_BYTES);
                    end
                    else
                    begin
                        byte_total_next = byte_total_reg + 64'(FULL_BYTES);
                    end
                end
            end
            ST_PAD:
            begin
                slot_next = 4'(slot_reg + 4'd1);
                if (pend_pad_reg)
                    pend_pad_next = 1'b0;
                else if (slot_reg == SLOT_LEN_LO)
                    len_lo_next = 1'b1;
                else if (slot_reg == SLOT_LEN_HI && len_lo_reg)
                    fin_next = 1'b1;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    idx_next = 2'(idx_reg + 2'd1);
                    if (idx_reg == LAST_INDEX)
                    begin
                        byte_total_next = 64'd0;
                        pad_next        = 1'b0;
                        len_lo_next     = 1'b0;
                        fin_next        = 1'b0;
                        pend_pad_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_reg       <= 4'd0;
            byte_total_reg <= 64'd0;
            pend_pad_reg   <= 1'b0;
            len_lo_reg     <= 1'b0;
            fin_reg        <= 1'b0;
            pad_reg        <= 1'b0;
            idx_reg        <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            byte_total_reg <= byte_total_next;
            pend_pad_reg   <= pend_pad_next;
            len_lo_reg     <= len_lo_next;
            fin_reg        <= fin_next;
            pad_reg        <= pad_next;
            idx_reg        <= idx_next;
        end
    end

endmodule

`default_nettype wire

@@ src/md5_round_unit.sv @@
// md5_round_unit: block word memory, a/b/c/d working registers and chaining words
// runs one md5 round per cycle out of the memory; depends on md5_pkg
`default_nettype none

module md5_round_unit
    import md5_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ru_ctrl_t ctrl,
    output ru_stat_t      stat
);

    ru_state_t   state_reg, state_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    chain_t      chain_reg, chain_next;

    // block word memory, one write and one registered read per cycle
    logic [31:0] block_mem [16];
    logic [3:0]  rd_addr;
    logic [31:0] rd_data_reg;

    logic [31:0] f_val;
    logic [31:0] round_sum;
    logic [31:0] b_new;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            block_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        rd_data_reg <= block_mem[rd_addr];
    end

    // read one round ahead so the word lands with its round
    assign rd_addr = (state_reg == RU_LOAD) ? 4'd0 : msg_index(6'(rnd_reg + 6'd1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            RU_IDLE:  if (ctrl.start) state_next = RU_LOAD;
            RU_LOAD:  state_next = RU_ROUND;
            RU_ROUND: if (rnd_reg == LAST_ROUND) state_next = RU_ADD;
            RU_ADD:   state_next = RU_IDLE;
            default:  state_next = RU_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        stat.done  = (state_reg == RU_ADD);
        stat.chain = chain_reg;
    end

    // round function
    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        round_sum = a_reg + f_val + SINE_K[rnd_reg] + rd_data_reg;
        b_new     = b_reg + rotl32(round_sum, rot_amount(rnd_reg));
    end

    // working register and chaining updates
    always_comb
    begin
        rnd_next   = rnd_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        chain_next = chain_reg;
        case (state_reg)
            RU_LOAD:
            begin
                rnd_next = 6'd0;
                a_next   = chain_reg[0];
                b_next   = chain_reg[1];
                c_next   = chain_reg[2];
                d_next   = chain_reg[3];
            end
            RU_ROUND:
            begin
                rnd_next = 6'(rnd_reg + 6'd1);
                a_next   = d_reg;
                d_next   = c_reg;
                c_next   = b_reg;
                b_next   = b_new;
            end
            RU_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
            end
            default:
            begin
                rnd_next = rnd_reg;
            end
        endcase
        if (ctrl.clear_chain)
        begin
            chain_next = {IV_H3, IV_H2, IV_H1, IV_H0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RU_IDLE;
            rnd_reg   <= 6'd0;
            a_reg     <= 32'd0;
            b_reg     <= 32'd0;
            c_reg     <= 32'd0;
            d_reg     <= 32'd0;
            chain_reg <= {IV_H3, IV_H2, IV_H1, IV_H0};
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            chain_reg <= chain_next;
        end
    end

endmodule

`default_nettype wire

@@ src/md5_checker.sv @@
// md5_port_checker: port-level assertions for md5_digest_engine, bound to the top level
// no dependencies beyond the top level's ports
`default_nettype none

module md5_port_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("digest word changed while stalled");

    // no input taken while the digest is being sent
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready during digest output");

    // digest words come in order without gaps
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser != 2'd3 |=> m_tvalid && m_tuser == $past(m_tuser) + 2'd1)
        else $error("digest index out of sequence");

    // last mark only on h3
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
        else $error("digest last mark misplaced");

    // a final word always starts padding or a block run, so input closes right after it
    a_tail_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open right after final word");

endmodule

bind md5_digest_engine md5_port_checker u_md5_checker (.*);

`default_nettype wire
